// ===== design/assert_macros.svh =====
// Assertion helpers shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset.
`define AFD_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("deframer assertion failed");

// Antecedent requires the consequent in the same cycle.
`define AFD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Antecedent requires the consequent in the next cycle.
`define AFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// ===== design/afd_pkg.sv =====
package afd_pkg;

  localparam int DATA_W             = 8;
  localparam int MAX_DATA_BYTES_DEF = 64;
  localparam int MAX_RESULTS        = 60;
  localparam int FLEN_W             = 7;   // frame length, covers the largest store depth
  localparam int PLEN_W             = 7;   // payload_length port width
  localparam int PADDR_W            = 5;
  localparam int PDATA_W            = 32;

  // Frame layout
  localparam int HDR_BYTES     = 12;  // bytes read back before decode
  localparam int HDR_CNT_W     = 4;
  localparam int RX_HDR_BYTES  = 12;
  localparam int TX_MIN_BYTES  = 7;
  localparam int MDM_MIN_BYTES = 2;
  localparam int AT_HDR_BYTES  = 5;
  localparam logic [DATA_W-1:0] CKSUM_GOOD = 8'hFF;

  // Register reset values
  localparam logic [DATA_W-1:0] START_DELIM_RST = 8'h7E;
  localparam logic [DATA_W-1:0] RX_TYPE_RST     = 8'h90;
  localparam logic [DATA_W-1:0] TX_TYPE_RST     = 8'h8B;
  localparam logic [DATA_W-1:0] MDM_TYPE_RST    = 8'h8A;
  localparam logic [DATA_W-1:0] AT_TYPE_RST     = 8'h88;

  typedef enum logic [2:0] {
    REG_START_DELIM = 3'd0,
    REG_RX_TYPE     = 3'd1,
    REG_TX_TYPE     = 3'd2,
    REG_MDM_TYPE    = 3'd3,
    REG_AT_TYPE     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_RX_PACKET = 3'd0,
    KIND_TX_STATUS = 3'd1,
    KIND_MODEM     = 3'd2,
    KIND_AT_RESP   = 3'd3,
    KIND_OTHER     = 3'd4,
    KIND_CKSUM_ERR = 3'd5,
    KIND_OVERSIZE  = 3'd6,
    KIND_PAYLOAD   = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    REQ_DECODE    = 2'd0,
    REQ_CKSUM_ERR = 2'd1,
    REQ_OVERSIZE  = 2'd2
  } req_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] start_delimiter;
    logic [DATA_W-1:0] rx_packet_type;
    logic [DATA_W-1:0] tx_status_type;
    logic [DATA_W-1:0] modem_status_type;
    logic [DATA_W-1:0] at_response_type;
  } cfg_t;

  // End-of-frame request from the parser to the emitter
  typedef struct packed {
    logic              valid;
    req_op_t           op;
    logic [FLEN_W-1:0] len;
  } req_t;

  typedef struct packed {
    kind_t             kind;
    logic              last;
    logic [DATA_W-1:0] payload_byte;
    logic [PLEN_W-1:0] payload_length;
    logic [63:0]       source_address;
    logic [DATA_W-1:0] frame_id;
    logic [DATA_W-1:0] status_code;
    logic [DATA_W-1:0] receive_options;
    logic [DATA_W-1:0] retry_count;
    logic [DATA_W-1:0] discovery_status;
    logic [DATA_W-1:0] command_high;
    logic [DATA_W-1:0] command_low;
  } res_t;

endpackage

// ===== design/afd_frame_ram.sv =====
`include "assert_macros.svh"

module afd_frame_ram #(
  parameter int DEPTH  = afd_pkg::MAX_DATA_BYTES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [afd_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [afd_pkg::DATA_W-1:0] rdata
);
  import afd_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Writes come only while reception runs, reads only while the emitter drains
  `AFD_ASSERT_NEVER(a_no_rw_overlap, clk, rst, we && re)

endmodule

// ===== design/afd_parser.sv =====
module afd_parser #(
  parameter int MAX_DATA_BYTES = afd_pkg::MAX_DATA_BYTES_DEF,
  parameter int ADDR_W         = $clog2(MAX_DATA_BYTES)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [afd_pkg::DATA_W-1:0] rx_byte,
  input  afd_pkg::cfg_t              cfg,
  output logic                       ram_we,
  output logic [ADDR_W-1:0]          ram_waddr,
  output logic [afd_pkg::DATA_W-1:0] ram_wdata,
  output afd_pkg::req_t              req
);
  import afd_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_DATA,
    PH_CHECK
  } phase_t;

  phase_t            parse_phase;
  logic [DATA_W-1:0] len_hi;
  logic [FLEN_W-1:0] expected_length;
  logic [FLEN_W-1:0] received_count;
  logic [DATA_W-1:0] running_sum;

  logic [15:0]       full_len;
  logic              len_zero;
  logic              len_over;
  logic [FLEN_W-1:0] count_inc;
  logic [DATA_W-1:0] sum_chk;

  assign full_len  = {len_hi, rx_byte};
  assign len_zero  = (full_len == 16'd0);
  assign len_over  = (full_len > 16'(MAX_DATA_BYTES));
  assign count_inc = received_count + FLEN_W'(1);
  assign sum_chk   = running_sum + rx_byte;

  assign ram_we    = accept && (parse_phase == PH_DATA);
  assign ram_waddr = received_count[ADDR_W-1:0];
  assign ram_wdata = rx_byte;

  always_comb begin
    req       = '0;
    req.op    = REQ_DECODE;
    req.len   = expected_length;
    if (accept && parse_phase == PH_LEN_LO && !len_zero && len_over) begin
      req.valid = 1'b1;
      req.op    = REQ_OVERSIZE;
    end else if (accept && parse_phase == PH_CHECK) begin
      req.valid = 1'b1;
      req.op    = (sum_chk == CKSUM_GOOD) ? REQ_DECODE : REQ_CKSUM_ERR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_WAIT;
      expected_length <= '0;
      received_count  <= '0;
      running_sum     <= '0;
    end else if (accept) begin
      case (parse_phase)
        PH_WAIT: begin
          if (rx_byte == cfg.start_delimiter) begin
            parse_phase <= PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_hi      <= rx_byte;
          parse_phase <= PH_LEN_LO;
        end
        PH_LEN_LO: begin
          received_count <= '0;
          running_sum    <= '0;
          if (len_zero || len_over) begin
            parse_phase <= PH_WAIT;
          end else begin
            expected_length <= full_len[FLEN_W-1:0];
            parse_phase     <= PH_DATA;
          end
        end
        PH_DATA: begin
          received_count <= count_inc;
          running_sum    <= sum_chk;
          if (count_inc >= expected_length) begin
            parse_phase <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          parse_phase <= PH_WAIT;
        end
        default: begin
          parse_phase <= PH_WAIT;
        end
      endcase
    end
  end

endmodule

// ===== design/afd_emitter.sv =====
`include "assert_macros.svh"

module afd_emitter #(
  parameter int ADDR_W = $clog2(afd_pkg::MAX_DATA_BYTES_DEF)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  afd_pkg::req_t              req,
  input  afd_pkg::cfg_t              cfg,
  output logic                       busy,
  output logic                       ram_re,
  output logic [ADDR_W-1:0]          ram_raddr,
  input  logic [afd_pkg::DATA_W-1:0] ram_rdata,
  output logic                       out_valid,
  input  logic                       out_stall,
  output afd_pkg::res_t              res
);
  import afd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_DECODE,
    ST_OUT,
    ST_PL_CAP
  } state_t;

  state_t               state;
  logic [HDR_CNT_W-1:0] hdr_cnt;
  logic [DATA_W-1:0]    hdr [HDR_BYTES];
  logic [FLEN_W-1:0]    frame_len;
  logic [PLEN_W-1:0]    pl_left;
  logic [ADDR_W-1:0]    pl_addr;

  logic                 out_take;
  res_t                 dec_res;
  res_t                 err_res;
  res_t                 pl_res;
  logic [PLEN_W-1:0]    dec_plen;
  logic [ADDR_W-1:0]    dec_first;
  logic [FLEN_W-1:0]    rx_rem;
  logic [FLEN_W-1:0]    at_rem;
  logic [PLEN_W-1:0]    rx_plen;
  logic [PLEN_W-1:0]    at_plen;

  assign out_take  = out_valid && !out_stall;
  assign busy      = (state != ST_IDLE);
  assign ram_re    = (state == ST_HDR && hdr_cnt < HDR_CNT_W'(HDR_BYTES)) ||
                     (state == ST_OUT && out_take && pl_left != '0);
  assign ram_raddr = (state == ST_HDR) ? ADDR_W'(hdr_cnt) : pl_addr;

  // Payload counts, capped so that one frame gives at most MAX_RESULTS results
  assign rx_rem  = frame_len - FLEN_W'(RX_HDR_BYTES);
  assign at_rem  = frame_len - FLEN_W'(AT_HDR_BYTES);
  assign rx_plen = (rx_rem > FLEN_W'(MAX_RESULTS - 1)) ? PLEN_W'(MAX_RESULTS - 1)
                                                       : PLEN_W'(rx_rem);
  assign at_plen = (at_rem > FLEN_W'(MAX_RESULTS - 1)) ? PLEN_W'(MAX_RESULTS - 1)
                                                       : PLEN_W'(at_rem);

  // Single-result status and payload byte transactions
  always_comb begin
    err_res             = '0;
    err_res.kind        = (req.op == REQ_CKSUM_ERR) ? KIND_CKSUM_ERR : KIND_OVERSIZE;
    err_res.last        = 1'b1;
    pl_res              = '0;
    pl_res.kind         = KIND_PAYLOAD;
    pl_res.payload_byte = ram_rdata;
    pl_res.last         = (pl_left == PLEN_W'(1));
  end

  always_comb begin
    dec_res      = '0;
    dec_res.kind = KIND_OTHER;
    dec_res.last = 1'b1;
    dec_plen     = '0;
    dec_first    = ADDR_W'(RX_HDR_BYTES);
    if (hdr[0] == cfg.rx_packet_type) begin
      if (frame_len >= FLEN_W'(RX_HDR_BYTES)) begin
        dec_res.kind            = KIND_RX_PACKET;
        dec_res.payload_length  = rx_plen;
        dec_res.source_address  = {hdr[1], hdr[2], hdr[3], hdr[4],
                                   hdr[5], hdr[6], hdr[7], hdr[8]};
        dec_res.receive_options = hdr[11];
        dec_res.last            = (rx_plen == '0);
        dec_plen                = rx_plen;
      end
    end else if (hdr[0] == cfg.tx_status_type) begin
      if (frame_len >= FLEN_W'(TX_MIN_BYTES)) begin
        dec_res.kind             = KIND_TX_STATUS;
        dec_res.frame_id         = hdr[1];
        dec_res.retry_count      = hdr[4];
        dec_res.status_code      = hdr[5];
        dec_res.discovery_status = hdr[6];
      end
    end else if (hdr[0] == cfg.modem_status_type) begin
      if (frame_len >= FLEN_W'(MDM_MIN_BYTES)) begin
        dec_res.kind        = KIND_MODEM;
        dec_res.status_code = hdr[1];
      end
    end else if (hdr[0] == cfg.at_response_type) begin
      if (frame_len >= FLEN_W'(AT_HDR_BYTES)) begin
        dec_res.kind           = KIND_AT_RESP;
        dec_res.payload_length = at_plen;
        dec_res.frame_id       = hdr[1];
        dec_res.command_high   = hdr[2];
        dec_res.command_low    = hdr[3];
        dec_res.status_code    = hdr[4];
        dec_res.last           = (at_plen == '0);
        dec_plen               = at_plen;
        dec_first              = ADDR_W'(AT_HDR_BYTES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      hdr_cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            frame_len <= req.len;
            case (req.op)
              REQ_DECODE: begin
                hdr_cnt <= '0;
                state   <= ST_HDR;
              end
              REQ_CKSUM_ERR: begin
                res       <= err_res;
                pl_left   <= '0;
                out_valid <= 1'b1;
                state     <= ST_OUT;
              end
              default: begin
                res       <= err_res;
                pl_left   <= '0;
                out_valid <= 1'b1;
                state     <= ST_OUT;
              end
            endcase
          end
        end
        ST_HDR: begin
          // Read data arrives in the cycle after its address
          if (hdr_cnt != '0) begin
            hdr[hdr_cnt - HDR_CNT_W'(1)] <= ram_rdata;
          end
          if (hdr_cnt == HDR_CNT_W'(HDR_BYTES)) begin
            state <= ST_DECODE;
          end else begin
            hdr_cnt <= hdr_cnt + HDR_CNT_W'(1);
          end
        end
        ST_DECODE: begin
          res       <= dec_res;
          pl_left   <= dec_plen;
          pl_addr   <= dec_first;
          out_valid <= 1'b1;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (out_take) begin
            out_valid <= 1'b0;
            if (pl_left != '0) begin
              pl_addr <= pl_addr + ADDR_W'(1);
              state   <= ST_PL_CAP;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_PL_CAP: begin
          res       <= pl_res;
          pl_left   <= pl_left - PLEN_W'(1);
          out_valid <= 1'b1;
          state     <= ST_OUT;
        end
        default: begin
          state     <= ST_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  `AFD_ASSERT_IMPLIES(a_req_only_idle, clk, rst, req.valid, state == ST_IDLE)
  `AFD_ASSERT_NEXT(a_more_after_not_last, clk, rst, out_take && !res.last, state == ST_PL_CAP)
  `AFD_ASSERT_NEVER(a_idle_no_result, clk, rst, state == ST_IDLE && out_valid)

endmodule

// ===== design/api_frame_deframer.sv =====
// Deframer for length-prefixed serial API frames. One received byte is one
// input transaction: the block hunts for the start delimiter, reads a
// big-endian 16-bit length, stores the frame data in a single-port-read frame
// RAM and checks the trailing checksum byte (data sum plus checksum equals
// 0xFF). Hunting, length and data bytes are taken one per clock while
// in_stall is low. At the checksum byte, and at an oversize length, the block
// raises in_stall until every result of that transaction is delivered: an
// oversize length or bad checksum gives one result in the next cycle; a good
// frame first reads its 12 header bytes back from the RAM and decodes them
// into the header result, then gives each payload byte through a RAM read
// and the output register; out_stall can hold any result. Frames longer than
// MAX_DATA_BYTES are dropped as oversize; a zero length resyncs silently.
// Registers (APB, byte address 4 * index): start delimiter, then the receive
// packet, transmit status, modem status and AT response type codes; write
// them only while idle.
module api_frame_deframer #(
  parameter int MAX_DATA_BYTES = afd_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [afd_pkg::PADDR_W-1:0] paddr,
  input  logic [afd_pkg::PDATA_W-1:0] pwdata,
  output logic [afd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  // byte input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [afd_pkg::DATA_W-1:0]  rx_byte,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  kind,
  output logic                        last,
  output logic [afd_pkg::DATA_W-1:0]  payload_byte,
  output logic [afd_pkg::PLEN_W-1:0]  payload_length,
  output logic [63:0]                 source_address,
  output logic [afd_pkg::DATA_W-1:0]  frame_id,
  output logic [afd_pkg::DATA_W-1:0]  status_code,
  output logic [afd_pkg::DATA_W-1:0]  receive_options,
  output logic [afd_pkg::DATA_W-1:0]  retry_count,
  output logic [afd_pkg::DATA_W-1:0]  discovery_status,
  output logic [afd_pkg::DATA_W-1:0]  command_high,
  output logic [afd_pkg::DATA_W-1:0]  command_low
);
  import afd_pkg::*;

  localparam int ADDR_W = $clog2(MAX_DATA_BYTES);

  cfg_t              cfg;
  reg_idx_t          reg_idx;
  logic              cfg_wr;
  logic              in_take;
  logic              busy;
  req_t              req;
  res_t              res;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Register file: zero-wait APB, write completes in the access phase
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{START_DELIM_RST, RX_TYPE_RST, TX_TYPE_RST, MDM_TYPE_RST, AT_TYPE_RST};
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_START_DELIM: cfg.start_delimiter   <= pwdata[DATA_W-1:0];
        REG_RX_TYPE:     cfg.rx_packet_type    <= pwdata[DATA_W-1:0];
        REG_TX_TYPE:     cfg.tx_status_type    <= pwdata[DATA_W-1:0];
        REG_MDM_TYPE:    cfg.modem_status_type <= pwdata[DATA_W-1:0];
        REG_AT_TYPE:     cfg.at_response_type  <= pwdata[DATA_W-1:0];
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_START_DELIM: prdata = PDATA_W'(cfg.start_delimiter);
      REG_RX_TYPE:     prdata = PDATA_W'(cfg.rx_packet_type);
      REG_TX_TYPE:     prdata = PDATA_W'(cfg.tx_status_type);
      REG_MDM_TYPE:    prdata = PDATA_W'(cfg.modem_status_type);
      REG_AT_TYPE:     prdata = PDATA_W'(cfg.at_response_type);
      default:         prdata = '0;
    endcase
  end

  // Hold input while the emitter drains a finished frame
  assign in_stall = busy;
  assign in_take  = in_valid && !in_stall;

  afd_parser #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES),
    .ADDR_W         (ADDR_W)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_take),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .req       (req)
  );

  afd_frame_ram #(
    .DEPTH  (MAX_DATA_BYTES),
    .ADDR_W (ADDR_W)
  ) u_frame_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  afd_emitter #(
    .ADDR_W (ADDR_W)
  ) u_emitter (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .busy      (busy),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Unpack the result register onto the ports
  assign kind             = res.kind;
  assign last             = res.last;
  assign payload_byte     = res.payload_byte;
  assign payload_length   = res.payload_length;
  assign source_address   = res.source_address;
  assign frame_id         = res.frame_id;
  assign status_code      = res.status_code;
  assign receive_options  = res.receive_options;
  assign retry_count      = res.retry_count;
  assign discovery_status = res.discovery_status;
  assign command_high     = res.command_high;
  assign command_low      = res.command_low;

endmodule
